// ===== rtl/core/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared types and constants for the HSL to RGB conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl2rgb_pkg;

   localparam int FIELD_W    = 16;
   localparam int NUM_STAGES = 5;

   // hue ramp segment of one channel
   typedef enum logic [1:0] {
      RGN_RISE,
      RGN_TOP,
      RGN_FALL,
      RGN_LOW
   } ramp_region_type;

   // per-stage load enables, stage 1 at the input side
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } pipe_load_type;

endpackage

`default_nettype wire

// ===== rtl/core/hsl_to_rgb_convert.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_convert
// HSL plus alpha to RGB plus alpha, unsigned fixed point, ONE = 2^FRAC_BITS.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  hue, saturation, lightness, alpha
//   rsp_      out        rsp_valid / rsp_stall  red, green, blue, alpha_out
//
// Throughput one request per cycle while rsp_stall is low; five register
// stages (input/clamp, s*l product, helper levels, slope product, output).
// Synchronous reset clears only the stage valid bits.
// rsp_stall holds the output stage; empty stages upstream keep filling.
// req_stall rises only when all five stages hold requests and the output
// is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_to_rgb_convert #(
   parameter int FRAC_BITS = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_hue,
   input  wire logic [15:0] req_saturation,
   input  wire logic [15:0] req_lightness,
   input  wire logic [15:0] req_alpha,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [15:0] rsp_red,
   output logic      [15:0] rsp_green,
   output logic      [15:0] rsp_blue,
   output logic      [15:0] rsp_alpha_out
);

   localparam int NS = hsl2rgb_pkg::NUM_STAGES;
   localparam int FW = hsl2rgb_pkg::FIELD_W;
   localparam int VW = FRAC_BITS + 1;
   localparam int IW = (VW > FW) ? VW : FW;
   localparam logic [IW-1:0] ONE_I  = IW'(1) << FRAC_BITS;
   localparam logic [VW-1:0] ONE_V  = VW'(1) << FRAC_BITS;
   localparam logic [VW-1:0] THIRD_V = VW'(((2 ** FRAC_BITS) + 1) / 3);
   localparam logic [VW-1:0] TWO3_V  = ONE_V - THIRD_V;

   logic [NS-1:0]  valid_ff, valid_in;
   logic [NS-1:0]  rdy;
   logic [FW-1:0]  alpha_ff [NS];
   logic [VW-1:0]  sat1_ff, lit1_ff;
   hsl2rgb_pkg::pipe_load_type load;

   logic [IW-1:0]  hue_i, sat_i, lit_i;
   logic [VW-1:0]  sat_c, lit_c;
   logic [FRAC_BITS-1:0] hue_f;
   logic [VW-1:0]  t_red_sum, t_blue_sum;

   logic [VW-1:0]  hi_s3, lo_s3, diff_s3;
   logic [VW-1:0]  red_s5, green_s5, blue_s5;
   logic [IW-1:0]  red_x, green_x, blue_x;

   // stage control: a stage loads when it is empty or its contents move on
   always_comb begin
      rdy[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in = {valid_ff[NS-2:0], req_valid};
   end

   assign load.s1 = rdy[0];
   assign load.s2 = rdy[1];
   assign load.s3 = rdy[2];
   assign load.s4 = rdy[3];
   assign load.s5 = rdy[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // input clamp and hue offsets
   always_comb begin
      hue_i = IW'(req_hue);
      sat_i = IW'(req_saturation);
      lit_i = IW'(req_lightness);
      hue_f = hue_i[FRAC_BITS-1:0];
      sat_c = (sat_i > ONE_I) ? ONE_V : sat_i[VW-1:0];
      lit_c = (lit_i > ONE_I) ? ONE_V : lit_i[VW-1:0];
      t_red_sum  = {1'b0, hue_f} + THIRD_V;
      t_blue_sum = {1'b0, hue_f} + TWO3_V;
   end

   always_ff @(posedge clock) begin
      if (load.s1) begin
         sat1_ff     <= sat_c;
         lit1_ff     <= lit_c;
         alpha_ff[0] <= req_alpha;
      end
      for (int k = 1; k < NS; k++) begin
         if (rdy[k]) begin
            alpha_ff[k] <= alpha_ff[k-1];
         end
      end
   end

   hsl2rgb_level #(.FRAC_BITS(FRAC_BITS)) u_level (
      .clock   (clock),
      .load    (load),
      .sat_s1  (sat1_ff),
      .lit_s1  (lit1_ff),
      .hi_s3   (hi_s3),
      .lo_s3   (lo_s3),
      .diff_s3 (diff_s3)
   );

   hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_red (
      .clock   (clock),
      .load    (load),
      .hue_t   (t_red_sum[FRAC_BITS-1:0]),
      .hi_s3   (hi_s3),
      .lo_s3   (lo_s3),
      .diff_s3 (diff_s3),
      .chan_s5 (red_s5)
   );

   hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_green (
      .clock   (clock),
      .load    (load),
      .hue_t   (hue_f),
      .hi_s3   (hi_s3),
      .lo_s3   (lo_s3),
      .diff_s3 (diff_s3),
      .chan_s5 (green_s5)
   );

   hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_blue (
      .clock   (clock),
      .load    (load),
      .hue_t   (t_blue_sum[FRAC_BITS-1:0]),
      .hi_s3   (hi_s3),
      .lo_s3   (lo_s3),
      .diff_s3 (diff_s3),
      .chan_s5 (blue_s5)
   );

   assign red_x   = IW'(red_s5);
   assign green_x = IW'(green_s5);
   assign blue_x  = IW'(blue_s5);

   assign req_stall     = !rdy[0];
   assign rsp_valid     = valid_ff[NS-1];
   assign rsp_red       = red_x[FW-1:0];
   assign rsp_green     = green_x[FW-1:0];
   assign rsp_blue      = blue_x[FW-1:0];
   assign rsp_alpha_out = alpha_ff[NS-1];

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request not captured in stage 1");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("input stalled with a free stage");

   a_stage4_held: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !load.s5) |=> valid_ff[3])
      else $error("stage 4 request lost while blocked");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (red_s5 <= ONE_V && green_s5 <= ONE_V && blue_s5 <= ONE_V))
      else $error("channel level above one");

endmodule

`default_nettype wire

// ===== rtl/core/hsl2rgb_level.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_level
// Helper levels: stage 2 forms saturation * lightness, stage 3 the high and
// low levels and their difference.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_level #(
   parameter int FRAC_BITS = 15
) (
   input  wire logic                          clock,
   input  wire hsl2rgb_pkg::pipe_load_type    load,
   input  wire logic [FRAC_BITS:0]            sat_s1,
   input  wire logic [FRAC_BITS:0]            lit_s1,
   output logic      [FRAC_BITS:0]            hi_s3,
   output logic      [FRAC_BITS:0]            lo_s3,
   output logic      [FRAC_BITS:0]            diff_s3
);

   localparam int VW = FRAC_BITS + 1;
   localparam int PW = 2 * VW;
   localparam logic [VW-1:0] ONE_V  = VW'(1) << FRAC_BITS;
   localparam logic [VW-1:0] HALF_V = VW'(1) << (FRAC_BITS - 1);
   localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);

   logic [PW-1:0] prod_ff, prod_in;
   logic [VW-1:0] sat2_ff, lit2_ff;
   logic          dark2_ff;
   logic [VW-1:0] hi_ff, hi_in;
   logic [VW-1:0] lo_ff, lo_in;
   logic [VW-1:0] diff_ff, diff_in;

   logic [PW-1:0] prod_rnd;
   logic [VW-1:0] pr;
   logic [VW:0]   hi_raw;
   logic [VW:0]   two_l;
   logic [VW:0]   lo_raw;

   assign prod_in = PW'(sat_s1) * PW'(lit_s1);

   always_ff @(posedge clock) begin
      if (load.s2) begin
         prod_ff  <= prod_in;
         sat2_ff  <= sat_s1;
         lit2_ff  <= lit_s1;
         dark2_ff <= lit_s1 < HALF_V;
      end
   end

   always_comb begin
      prod_rnd = prod_ff + HALF_P;
      pr       = prod_rnd[FRAC_BITS +: VW];
      if (dark2_ff) begin
         hi_raw = {1'b0, lit2_ff} + {1'b0, pr};
      end else begin
         hi_raw = {1'b0, lit2_ff} + {1'b0, sat2_ff} - {1'b0, pr};
      end
      hi_in  = (hi_raw > {1'b0, ONE_V}) ? ONE_V : hi_raw[VW-1:0];
      two_l  = {lit2_ff, 1'b0};
      lo_raw = (two_l > {1'b0, hi_in}) ? two_l - {1'b0, hi_in} : '0;
      lo_in  = (lo_raw > {1'b0, hi_in}) ? hi_in : lo_raw[VW-1:0];
      diff_in = hi_in - lo_in;
   end

   always_ff @(posedge clock) begin
      if (load.s3) begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         diff_ff <= diff_in;
      end
   end

   assign hi_s3   = hi_ff;
   assign lo_s3   = lo_ff;
   assign diff_s3 = diff_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hsl2rgb_ramp.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_ramp
// One color channel: segment and slope factor from the hue at stage 1,
// slope product at stage 4, channel level at stage 5.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_ramp #(
   parameter int FRAC_BITS = 15
) (
   input  wire logic                          clock,
   input  wire hsl2rgb_pkg::pipe_load_type    load,
   input  wire logic [FRAC_BITS-1:0]          hue_t,
   input  wire logic [FRAC_BITS:0]            hi_s3,
   input  wire logic [FRAC_BITS:0]            lo_s3,
   input  wire logic [FRAC_BITS:0]            diff_s3,
   output logic      [FRAC_BITS:0]            chan_s5
);

   localparam int VW = FRAC_BITS + 1;
   localparam int PW = 2 * VW;
   localparam int SW = FRAC_BITS + 3;
   localparam logic [SW-1:0] ONE_S  = SW'(1) << FRAC_BITS;
   localparam logic [SW-1:0] FOUR_S = SW'(4) << FRAC_BITS;
   localparam logic [FRAC_BITS-1:0] HALF_T = FRAC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);

   hsl2rgb_pkg::ramp_region_type rgn1_ff, rgn2_ff, rgn3_ff, rgn4_ff, rgn_in;
   logic [VW-1:0] fac1_ff, fac2_ff, fac3_ff, fac_in;
   logic [PW-1:0] prod4_ff, prod_in;
   logic [VW-1:0] lo4_ff, hi4_ff;
   logic [VW-1:0] chan_ff, chan_in;

   logic [SW-1:0] six_t;
   logic [SW-1:0] fall_f;
   logic [PW-1:0] prod_rnd;

   always_comb begin
      six_t  = ({3'b000, hue_t} << 2) + ({3'b000, hue_t} << 1);
      fall_f = FOUR_S - six_t;
      if (six_t < ONE_S) begin
         rgn_in = hsl2rgb_pkg::RGN_RISE;
         fac_in = six_t[VW-1:0];
      end else if (hue_t < HALF_T) begin
         rgn_in = hsl2rgb_pkg::RGN_TOP;
         fac_in = '0;
      end else if (six_t < FOUR_S) begin
         rgn_in = hsl2rgb_pkg::RGN_FALL;
         fac_in = fall_f[VW-1:0];
      end else begin
         rgn_in = hsl2rgb_pkg::RGN_LOW;
         fac_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load.s1) begin
         rgn1_ff <= rgn_in;
         fac1_ff <= fac_in;
      end
      if (load.s2) begin
         rgn2_ff <= rgn1_ff;
         fac2_ff <= fac1_ff;
      end
      if (load.s3) begin
         rgn3_ff <= rgn2_ff;
         fac3_ff <= fac2_ff;
      end
   end

   assign prod_in = PW'(diff_s3) * PW'(fac3_ff);

   always_ff @(posedge clock) begin
      if (load.s4) begin
         rgn4_ff  <= rgn3_ff;
         prod4_ff <= prod_in;
         lo4_ff   <= lo_s3;
         hi4_ff   <= hi_s3;
      end
   end

   always_comb begin
      prod_rnd = prod4_ff + HALF_P;
      case (rgn4_ff) inside
         hsl2rgb_pkg::RGN_RISE,
         hsl2rgb_pkg::RGN_FALL: chan_in = lo4_ff + prod_rnd[FRAC_BITS +: VW];
         hsl2rgb_pkg::RGN_TOP:  chan_in = hi4_ff;
         default:               chan_in = lo4_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load.s5) begin
         chan_ff <= chan_in;
      end
   end

   assign chan_s5 = chan_ff;

endmodule

`default_nettype wire

// ===== bench/tb_hsl_to_rgb_convert.sv =====
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb_convert
// Self-checking bench for the HSL plus alpha to RGB plus alpha converter.
// A short table of corner requests runs first: zero saturation, clamped
// saturation and lightness, hue wrap and every ramp boundary. Random requests
// follow under several idle and stall mixes, with drains between mixes. Each
// result is compared with a bit-exact fixed-point prediction of the conversion.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_convert;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                FIELD_W  = hsl2rgb_pkg::FIELD_W;
   localparam int                FRAC     = 15;
   localparam logic [63:0]       ONE      = 64'd1 << FRAC;
   localparam logic [63:0]       HALF     = 64'd1 << (FRAC - 1);
   localparam logic [63:0]       FRAC_MSK = ONE - 64'd1;
   localparam logic [63:0]       THIRD    = (ONE + 64'd1) / 64'd3;
   localparam int                N_DIRECT = 23;
   localparam int                N_RANDOM = 850;

   typedef struct packed {
      logic [FIELD_W-1:0] hue;
      logic [FIELD_W-1:0] saturation;
      logic [FIELD_W-1:0] lightness;
      logic [FIELD_W-1:0] alpha;
   } hsla_type;

   typedef struct packed {
      logic [FIELD_W-1:0] red;
      logic [FIELD_W-1:0] green;
      logic [FIELD_W-1:0] blue;
      logic [FIELD_W-1:0] alpha_out;
   } rgba_type;

   typedef struct packed {
      hsla_type color;
      logic     known;
      rgba_type want;
   } corner_row_type;

   typedef enum logic [1:0] {
      MODE_FREE,
      MODE_SEND_IDLE,
      MODE_RECV_STALL,
      MODE_BOTH
   } idle_mode_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [FIELD_W-1:0] req_hue        = '0;
   logic [FIELD_W-1:0] req_saturation = '0;
   logic [FIELD_W-1:0] req_lightness  = '0;
   logic [FIELD_W-1:0] req_alpha      = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [FIELD_W-1:0] rsp_red;
   logic [FIELD_W-1:0] rsp_green;
   logic [FIELD_W-1:0] rsp_blue;
   logic [FIELD_W-1:0] rsp_alpha_out;

   idle_mode_type mode = MODE_FREE;
   rgba_type      pending_colors[$];
   int            fail_count = 0;

   corner_row_type corner_rows [0:N_DIRECT-1] = '{
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000}},
      '{'{16'hFFFF, 16'h0000, 16'h8000, 16'h8000}, 1'b1,
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000}},
      '{'{16'h3039, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{16'h8000, 16'h8000, 16'h8000, 16'hFFFF}},
      '{'{16'h0000, 16'h0000, 16'h4000, 16'h0001}, 1'b1,
        '{16'h4000, 16'h4000, 16'h4000, 16'h0001}},
      '{'{16'h7FFF, 16'h0000, 16'h0001, 16'h7FFF}, 1'b1,
        '{16'h0001, 16'h0001, 16'h0001, 16'h7FFF}},
      '{'{16'h0000, 16'h8000, 16'h4000, 16'h8000}, 1'b0, '0},
      '{'{16'h2AAB, 16'h8000, 16'h4000, 16'h8000}, 1'b0, '0},
      '{'{16'h5555, 16'h8000, 16'h4000, 16'h8000}, 1'b0, '0},
      '{'{16'h7FFF, 16'h8000, 16'h4000, 16'h8000}, 1'b0, '0},
      '{'{16'h8000, 16'h8000, 16'h4000, 16'h8000}, 1'b0, '0},
      '{'{16'hFFFF, 16'h8000, 16'h4000, 16'h8000}, 1'b0, '0},
      '{'{16'h1555, 16'h8000, 16'h4000, 16'h4000}, 1'b0, '0},
      '{'{16'h1556, 16'h8000, 16'h4000, 16'h4000}, 1'b0, '0},
      '{'{16'h3FFF, 16'h8000, 16'h4000, 16'h4000}, 1'b0, '0},
      '{'{16'h4000, 16'h8000, 16'h4000, 16'h4000}, 1'b0, '0},
      '{'{16'h5556, 16'h8000, 16'h4000, 16'h4000}, 1'b0, '0},
      '{'{16'h2000, 16'hFFFF, 16'h8000, 16'hAAAA}, 1'b0, '0},
      '{'{16'h2000, 16'h0001, 16'h0001, 16'h5555}, 1'b0, '0},
      '{'{16'h6000, 16'h8000, 16'h3FFF, 16'h1234}, 1'b0, '0},
      '{'{16'h6000, 16'h8000, 16'h7FFF, 16'h8001}, 1'b0, '0},
      '{'{16'h1000, 16'h8000, 16'h0000, 16'hFFFF}, 1'b0, '0},
      '{'{16'h1000, 16'h4000, 16'hFFFF, 16'h0000}, 1'b0, '0},
      '{'{16'h4E20, 16'h1234, 16'h2345, 16'h0F0F}, 1'b0, '0}
   };

   hsl_to_rgb_convert uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_hue       (req_hue),
      .req_saturation(req_saturation),
      .req_lightness (req_lightness),
      .req_alpha     (req_alpha),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_alpha_out (rsp_alpha_out)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b);
      return (a * b + HALF) >> FRAC;
   endfunction

   function automatic logic [63:0] ramp_level(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [63:0] t);
      logic [63:0] span;
      span = hi - lo;
      if (6 * t < ONE) begin
         return lo + mul_round(span, 6 * t);
      end
      if (2 * t < ONE) begin
         return hi;
      end
      if (3 * t < 2 * ONE) begin
         return lo + mul_round(span, 4 * ONE - 6 * t);
      end
      return lo;
   endfunction

   function automatic rgba_type hsla_to_rgba(input hsla_type c);
      logic [63:0] h, s, l, hi, lo;
      rgba_type    res;
      h = {48'd0, c.hue} & FRAC_MSK;
      s = (c.saturation > ONE) ? ONE : {48'd0, c.saturation};
      l = (c.lightness > ONE) ? ONE : {48'd0, c.lightness};
      if (s == 0) begin
         res.red   = l[FIELD_W-1:0];
         res.green = l[FIELD_W-1:0];
         res.blue  = l[FIELD_W-1:0];
      end else begin
         if (l < HALF) begin
            hi = mul_round(l, ONE + s);
         end else begin
            hi = l + s - mul_round(s, l);
         end
         if (hi > ONE) begin
            hi = ONE;
         end
         lo = (2 * l > hi) ? 2 * l - hi : 64'd0;
         if (lo > hi) begin
            lo = hi;
         end
         res.red   = FIELD_W'(ramp_level(lo, hi, (h + THIRD) & FRAC_MSK));
         res.green = FIELD_W'(ramp_level(lo, hi, h));
         res.blue  = FIELD_W'(ramp_level(lo, hi, (h + ONE - THIRD) & FRAC_MSK));
      end
      res.alpha_out = c.alpha;
      return res;
   endfunction

   function automatic hsla_type random_color();
      hsla_type c;
      c.hue        = FIELD_W'($urandom_range(0, 32767));
      c.saturation = FIELD_W'($urandom_range(0, 32768));
      c.lightness  = FIELD_W'($urandom_range(0, 32768));
      c.alpha      = FIELD_W'($urandom_range(0, 32768));
      case ($urandom_range(0, 9))
         0: begin
            c = {$urandom, $urandom};
         end
         1: begin
            c.saturation = '0;
         end
         2: begin
            c.saturation = $urandom_range(0, 1) ? 16'h8000 : 16'h0001;
            c.lightness  = $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
         end
         3: begin
            c.lightness = FIELD_W'($urandom_range(16380, 16388));
         end
         default: begin
         end
      endcase
      return c;
   endfunction

   function automatic int send_idle_pct();
      return (mode == MODE_SEND_IDLE) ? 58 : (mode == MODE_BOTH) ? 35 : 0;
   endfunction

   function automatic int recv_stall_pct();
      return (mode == MODE_RECV_STALL) ? 58 : (mode == MODE_BOTH) ? 35 : 0;
   endfunction

   task automatic send_color(input hsla_type c, input logic known, input rgba_type want);
      while ($urandom_range(0, 99) < send_idle_pct()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= c.hue;
      req_saturation <= c.saturation;
      req_lightness  <= c.lightness;
      req_alpha      <= c.alpha;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_colors.insert(pending_colors.size(), known ? want : hsla_to_rgba(c));
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_color(input rgba_type got);
      rgba_type want;
      if (pending_colors.size() == 0) begin
         $display("%0t: unexpected result expected none actual r=%0d g=%0d b=%0d a=%0d",
                  $time, got.red, got.green, got.blue, got.alpha_out);
         fail_count++;
      end else begin
         want = pending_colors.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch exp r=%0d g=%0d b=%0d a=%0d act r=%0d g=%0d b=%0d a=%0d",
                     $time, want.red, want.green, want.blue, want.alpha_out,
                     got.red, got.green, got.blue, got.alpha_out);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_color('{rsp_red, rsp_green, rsp_blue, rsp_alpha_out});
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct());
      end
   end

   initial begin
      static idle_mode_type phases [0:4] = '{MODE_FREE, MODE_SEND_IDLE, MODE_RECV_STALL,
                                             MODE_BOTH, MODE_FREE};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECT; i++) begin
         send_color(corner_rows[i].color, corner_rows[i].known, corner_rows[i].want);
      end
      drain_pending();

      foreach (phases[p]) begin
         mode = phases[p];
         for (int i = 0; i < N_RANDOM / 5; i++) begin
            send_color(random_color(), 1'b0, '0);
         end
         drain_pending();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_colors.size() == 0) begin
         $display("PASS hsl_to_rgb_convert");
      end else begin
         $display("FAIL hsl_to_rgb_convert");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL hsl_to_rgb_convert");
      $finish;
   end

endmodule
